@@ rtl/wsog_pkg.sv @@
package wsog_pkg;

  // Widths of the result fields as they appear on the stream.
  localparam int unsigned IdxW = 24;
  localparam int unsigned PosW = 8;
  localparam int unsigned StgW = 10;

  // Register indexes of the configuration port (paddr[3:2]).
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  // Request kinds carried in tuser[0].
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  // One result of the generator.
  typedef struct packed {
    logic            valid_res;
    logic [IdxW-1:0] voxel_index;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [PosW-1:0] pos_z;
    logic [StgW-1:0] stage_number;
    logic            stage_end;
    logic            sweep_end;
  } res_t;

endpackage

@@ rtl/wsog_step.sv @@
module wsog_step
  import wsog_pkg::*;
#(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic [$clog2(MAX_DIM+1)-1:0] lat_x_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] lat_y_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] lat_z_i,
  input  logic [IdxW-1:0]              lat_yz_i,
  input  logic [2:0]                   dir_i,
  input  logic [$clog2(3*MAX_DIM)-1:0] stage_i,
  input  logic [$clog2(MAX_DIM)-1:0]   ox_i,
  input  logic [$clog2(MAX_DIM)-1:0]   oy_i,
  output res_t                         res_o,
  output logic                         done_o,
  output logic [$clog2(3*MAX_DIM)-1:0] stage_o,
  output logic [$clog2(MAX_DIM)-1:0]   ox_o,
  output logic [$clog2(MAX_DIM)-1:0]   oy_o
);

  localparam int unsigned DW = $clog2(MAX_DIM+1);
  localparam int unsigned OW = $clog2(MAX_DIM);
  localparam int unsigned SW = $clog2(3*MAX_DIM);

  logic [SW-1:0] lxm, lym, lzm, s, oxs, oys, oz, last;
  logic [SW-1:0] r, ymin, yzm, xmin, ox_dec, oy_fromx, s1, ox_first, oy_first;
  logic [SW-1:0] rem_x, rem_f;
  logic [OW-1:0] x, y, z;
  logic [OW+IdxW-1:0] p_x;
  logic [OW+DW-1:0]   p_y;
  logic [31:0] x32, y32, z32, s32;
  logic step_y, step_x;

  assign lxm = SW'(lat_x_i) - SW'(1);
  assign lym = SW'(lat_y_i) - SW'(1);
  assign lzm = SW'(lat_z_i) - SW'(1);
  assign s   = stage_i;
  assign oxs = SW'(ox_i);
  assign oys = SW'(oy_i);
  assign oz  = s - oxs - oys;

  // Offsets count away from the start corner; a clear direction bit
  // means the coordinate runs down from the far face.
  assign x = dir_i[2] ? ox_i : OW'(lxm - oxs);
  assign y = dir_i[1] ? oy_i : OW'(lym - oys);
  assign z = dir_i[0] ? OW'(oz) : OW'(lzm - oz);

  assign p_x = x * lat_yz_i;
  assign p_y = y * lat_z_i;

  assign x32 = 32'(x);
  assign y32 = 32'(y);
  assign z32 = 32'(z);
  assign s32 = 32'(s);

  // Closed-form bounds of the current stage.
  assign last = lxm + lym + lzm;
  assign r    = s - oxs;
  assign ymin = (r > lzm) ? r - lzm : '0;
  assign yzm  = lym + lzm;
  assign xmin = (s > yzm) ? s - yzm : '0;

  assign step_y = oys > ymin;
  assign step_x = oxs > xmin;

  assign ox_dec   = oxs - SW'(1);
  assign rem_x    = s - ox_dec;
  assign oy_fromx = (lym < rem_x) ? lym : rem_x;

  assign s1       = s + SW'(1);
  assign ox_first = (lxm < s1) ? lxm : s1;
  assign rem_f    = s1 - ox_first;
  assign oy_first = (lym < rem_f) ? lym : rem_f;

  always_comb begin
    res_o.valid_res    = 1'b1;
    res_o.voxel_index  = p_x[IdxW-1:0] + IdxW'(p_y) + IdxW'(z);
    res_o.pos_x        = x32[PosW-1:0];
    res_o.pos_y        = y32[PosW-1:0];
    res_o.pos_z        = z32[PosW-1:0];
    res_o.stage_number = s32[StgW-1:0];
    res_o.stage_end    = 1'b0;
    res_o.sweep_end    = 1'b0;
    done_o  = 1'b0;
    stage_o = s;
    ox_o    = ox_i;
    oy_o    = oy_i;
    if (step_y) begin
      oy_o = oy_i - OW'(1);
    end else if (step_x) begin
      ox_o = OW'(ox_dec);
      oy_o = OW'(oy_fromx);
    end else begin
      res_o.stage_end = 1'b1;
      if (s >= last) begin
        res_o.sweep_end = 1'b1;
        done_o          = 1'b1;
      end else begin
        stage_o = s1;
        ox_o    = OW'(ox_first);
        oy_o    = OW'(oy_first);
      end
    end
  end

endmodule

@@ rtl/wavefront_sweep_order_generator_unit.sv @@
// Wavefront sweep order generator. A request with tuser[0] = 0 starts a sweep
// in the octant given by tdata[2:0] (bit 2 x, bit 1 y, bit 0 z; a set bit means
// the coordinate runs up from zero) over the grid sizes held in the size_x,
// size_y and size_z registers, which are captured at that moment. Every later
// request with tuser[0] = 1 returns the next voxel: voxel by voxel through
// stages of growing distance from the start corner, with stage_end on the last
// voxel of a stage and tlast on the last voxel of the sweep. Start requests and
// requests with no sweep running give a result with valid_res low and all
// other fields zero. The unit takes one request per clock cycle and returns
// its result in the next cycle; the only thing that holds it up is a result
// waiting in the output register while the downstream side keeps tready low.
// The rate is set by one pass through the stepping logic, whose slowest path
// is the index multiply of the voxel x coordinate by the captured y*z plane size.
module wavefront_sweep_order_generator_unit
  import wsog_pkg::*;
#(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [2:0] octant, rest zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] kind
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [23:0] voxel_index, [31:24] pos_x,
                                        // [39:32] pos_y, [47:40] pos_z,
                                        // [57:48] stage_number, rest zero
  output logic [1:0]  m_axis_tuser_o,   // [0] valid_res, [1] stage_end
  output logic        m_axis_tlast_o    // sweep_end
);

  localparam int unsigned DW = $clog2(MAX_DIM+1);
  localparam int unsigned OW = $clog2(MAX_DIM);
  localparam int unsigned SW = $clog2(3*MAX_DIM);

  // Size registers hold the clamped value written by software.
  logic [DW-1:0] size_x_q, size_y_q, size_z_q;
  logic          cfg_wr;
  logic [DW-1:0] cfg_val;

  // Sweep state.
  logic          active_q, active_d;
  logic [2:0]    dir_q, dir_d;
  logic [SW-1:0] stage_q, stage_d;
  logic [OW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [DW-1:0] lat_x_q, lat_x_d, lat_y_q, lat_y_d, lat_z_q, lat_z_d;
  logic [IdxW-1:0] lat_yz_q, lat_yz_d;
  logic [2*DW-1:0] size_yz;

  // Output register.
  logic res_vld_q, res_vld_d;
  res_t res_q, res_d;

  // Stepping logic outputs.
  res_t          step_res;
  logic          step_done;
  logic [SW-1:0] step_stage;
  logic [OW-1:0] step_ox, step_oy;

  logic in_acc, kind;

  function automatic logic [DW-1:0] clamp_size(input logic [31:0] v);
    logic [DW-1:0] c;
    if (v == 32'd0) begin
      c = DW'(1);
    end else if (v > 32'(MAX_DIM)) begin
      c = DW'(MAX_DIM);
    end else begin
      c = v[DW-1:0];
    end
    return c;
  endfunction

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_val = clamp_size(pwdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= DW'(1);
      size_y_q <= DW'(1);
      size_z_q <= DW'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x_q <= cfg_val;
        REG_SIZE_Y: size_y_q <= cfg_val;
        REG_SIZE_Z: size_z_q <= cfg_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(size_x_q);
      REG_SIZE_Y: prdata = 32'(size_y_q);
      REG_SIZE_Z: prdata = 32'(size_z_q);
      default:    prdata = 32'd0;
    endcase
  end

  // A new request enters whenever the output register is empty or being
  // drained in this same cycle.
  assign s_axis_tready_o = ~res_vld_q | m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign kind            = s_axis_tuser_i[0];

  wsog_step #(
    .MAX_DIM (MAX_DIM)
  ) u_step (
    .lat_x_i  (lat_x_q),
    .lat_y_i  (lat_y_q),
    .lat_z_i  (lat_z_q),
    .lat_yz_i (lat_yz_q),
    .dir_i    (dir_q),
    .stage_i  (stage_q),
    .ox_i     (ox_q),
    .oy_i     (oy_q),
    .res_o    (step_res),
    .done_o   (step_done),
    .stage_o  (step_stage),
    .ox_o     (step_ox),
    .oy_o     (step_oy)
  );

  // The plane size is multiplied once at the start so that each voxel
  // needs only one multiply by it.
  assign size_yz = size_y_q * size_z_q;

  always_comb begin
    active_d  = active_q;
    dir_d     = dir_q;
    stage_d   = stage_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    lat_x_d   = lat_x_q;
    lat_y_d   = lat_y_q;
    lat_z_d   = lat_z_q;
    lat_yz_d  = lat_yz_q;
    res_vld_d = res_vld_q & ~m_axis_tready_i;
    res_d     = res_q;
    if (in_acc) begin
      res_vld_d = 1'b1;
      res_d     = '0;
      if (kind == KIND_START) begin
        lat_x_d  = size_x_q;
        lat_y_d  = size_y_q;
        lat_z_d  = size_z_q;
        lat_yz_d = IdxW'(size_yz);
        dir_d    = s_axis_tdata_i[2:0];
        active_d = 1'b1;
        stage_d  = '0;
        ox_d     = '0;
        oy_d     = '0;
      end else if (active_q) begin
        res_d    = step_res;
        active_d = ~step_done;
        stage_d  = step_stage;
        ox_d     = step_ox;
        oy_d     = step_oy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      dir_q     <= 3'd0;
      stage_q   <= '0;
      ox_q      <= '0;
      oy_q      <= '0;
      lat_x_q   <= DW'(1);
      lat_y_q   <= DW'(1);
      lat_z_q   <= DW'(1);
      lat_yz_q  <= IdxW'(1);
      res_vld_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      dir_q     <= dir_d;
      stage_q   <= stage_d;
      ox_q      <= ox_d;
      oy_q      <= oy_d;
      lat_x_q   <= lat_x_d;
      lat_y_q   <= lat_y_d;
      lat_z_q   <= lat_z_d;
      lat_yz_q  <= lat_yz_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = res_vld_q;
  assign m_axis_tdata_o  = {6'd0, res_q.stage_number, res_q.pos_z, res_q.pos_y,
                            res_q.pos_x, res_q.voxel_index};
  assign m_axis_tuser_o  = {res_q.stage_end, res_q.valid_res};
  assign m_axis_tlast_o  = res_q.sweep_end;

endmodule

@@ rtl/wsog_checker.sv @@
module wsog_checker
  import wsog_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [0:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled result must hold still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // The end of the sweep is always a real voxel that also closes its stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == 2'b11)
    else $error("sweep end without valid voxel or stage end");

  // A result without a voxel carries nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tdata_o == 64'd0 && !m_axis_tlast_o && !m_axis_tuser_o[1])
    else $error("empty result has nonzero fields");

  // An empty output register never blocks the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request side stalled with empty output");

  // A start request yields an empty result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0] == KIND_START |=>
      m_axis_tvalid_o && !m_axis_tuser_o[0])
    else $error("start request did not give an empty result");

endmodule

bind wavefront_sweep_order_generator_unit wsog_checker u_wsog_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for the wavefront sweep order generator.
//
// Requests go in on the slave stream. A start request (tuser = 0) picks an
// octant, and each next request (tuser = 1) asks for one voxel. Every request
// produces exactly one result on the master stream. A monitor watches both
// streams and the APB port at every rising edge. For each accepted request it
// runs a behavioral copy of the sweep stepping and queues the predicted result.
// For each accepted result it compares every field with the oldest prediction.
// Grid sizes are written over APB only when no result is outstanding. The
// monitor tracks those writes, so the predictor always works with the sizes
// that the block holds.
module tb_top;
  import wsog_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned MAX_EXTENT     = 256;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [2:0] octant, rest zero
  logic [0:0]  s_axis_tuser_i = '0;   // [0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // [23:0] voxel_index, [31:24] pos_x,
                                      // [39:32] pos_y, [47:40] pos_z,
                                      // [57:48] stage_number
  logic [1:0]  m_axis_tuser_o;        // [0] valid_res, [1] stage_end
  logic        m_axis_tlast_o;        // sweep_end

  wavefront_sweep_order_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // Shared state of the stimulus, the sink and the scoreboard.
  int unsigned fails = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps = 1'b0;      // suppresses idle cycles on both streams
  bit          rx_hold_req = 1'b0;  // asks the sink for one long stall
  bit          rx_holding = 1'b0;   // high while that stall is in progress
  res_t        voxel_expect_q[$];

  // Predictor state. The register copies hold the effective (clamped) sizes.
  // The latched copies are taken at each start request.
  int unsigned reg_size_x = 1, reg_size_y = 1, reg_size_z = 1;
  int unsigned grid_x = 1, grid_y = 1, grid_z = 1;
  bit          sweep_on = 1'b0;
  logic [2:0]  sweep_dir = '0;
  int unsigned cur_stage = 0, off_x = 0, off_y = 0;

  // A size of zero behaves as one, and anything above the maximum is capped.
  function automatic int unsigned eff_size(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_EXTENT) return MAX_EXTENT;
    return 32'(v);
  endfunction

  // Idle length for either stream: mostly none, sometimes short, rarely long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Advances the sweep by one request and returns the result it should give.
  // Offsets (ox, oy, oz) are measured from the start corner and ox+oy+oz is the
  // stage. Within a stage oy steps down first. Once oy reaches its floor, ox
  // steps down and oy restarts at its ceiling. When both reach their floors,
  // the stage is done.
  function automatic res_t sweep_step(input logic kind, input logic [2:0] oct);
    res_t        res;
    int unsigned s, ox, oy, oz, x, y, z, idx, rest, ymin, xmin, last_stage;
    res = '0;
    if (kind == KIND_START) begin
      grid_x    = reg_size_x;
      grid_y    = reg_size_y;
      grid_z    = reg_size_z;
      sweep_dir = oct;
      sweep_on  = 1'b1;
      cur_stage = 0;
      off_x     = 0;
      off_y     = 0;
      return res;
    end
    if (!sweep_on) return res;

    s  = cur_stage;
    ox = off_x;
    oy = off_y;
    oz = s - ox - oy;
    // A clear direction bit means that the coordinate counts down from the far face.
    x = sweep_dir[2] ? ox : grid_x - 1 - ox;
    y = sweep_dir[1] ? oy : grid_y - 1 - oy;
    z = sweep_dir[0] ? oz : grid_z - 1 - oz;
    idx = x * grid_y * grid_z + y * grid_z + z;

    last_stage = (grid_x - 1) + (grid_y - 1) + (grid_z - 1);
    rest = s - ox;
    ymin = (rest > grid_z - 1) ? rest - (grid_z - 1) : 0;
    if (oy > ymin) begin
      off_y = oy - 1;
    end else begin
      xmin = (s > (grid_y - 1) + (grid_z - 1)) ? s - (grid_y - 1) - (grid_z - 1) : 0;
      if (ox > xmin) begin
        off_x = ox - 1;
        off_y = (grid_y - 1 < s - off_x) ? grid_y - 1 : s - off_x;
      end else begin
        res.stage_end = 1'b1;
        if (s >= last_stage) begin
          res.sweep_end = 1'b1;
          sweep_on = 1'b0;
        end else begin
          cur_stage = s + 1;
          off_x = (grid_x - 1 < cur_stage) ? grid_x - 1 : cur_stage;
          off_y = (grid_y - 1 < cur_stage - off_x) ? grid_y - 1 : cur_stage - off_x;
        end
      end
    end

    res.valid_res    = 1'b1;
    res.voxel_index  = idx[IdxW-1:0];
    res.pos_x        = x[PosW-1:0];
    res.pos_y        = y[PosW-1:0];
    res.pos_z        = z[PosW-1:0];
    res.stage_number = s[StgW-1:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Scoreboard. At each edge it checks the result that is accepted, queues the
  // prediction for the request that is accepted, and follows register writes.
  // Outputs are read before the nonblocking updates of this edge, so they
  // hold the values that the handshake saw.
  always @(posedge clk_i) begin : scoreboard
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (voxel_expect_q.size() == 0) begin
          $error("result with nothing expected: tdata %h tuser %b tlast %b",
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          fails++;
        end else begin
          want = voxel_expect_q.pop_front();
          check_field("valid_res", 32'(want.valid_res), 32'(m_axis_tuser_o[0]));
          check_field("voxel_index", 32'(want.voxel_index), 32'(m_axis_tdata_o[23:0]));
          check_field("pos_x", 32'(want.pos_x), 32'(m_axis_tdata_o[31:24]));
          check_field("pos_y", 32'(want.pos_y), 32'(m_axis_tdata_o[39:32]));
          check_field("pos_z", 32'(want.pos_z), 32'(m_axis_tdata_o[47:40]));
          check_field("stage_number", 32'(want.stage_number),
                      32'(m_axis_tdata_o[57:48]));
          check_field("stage_end", 32'(want.stage_end), 32'(m_axis_tuser_o[1]));
          check_field("sweep_end", 32'(want.sweep_end), 32'(m_axis_tlast_o));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        voxel_expect_q.insert(voxel_expect_q.size(),
                              sweep_step(s_axis_tuser_i[0], s_axis_tdata_i[2:0]));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SIZE_X: reg_size_x = eff_size(pwdata[8:0]);
          REG_SIZE_Y: reg_size_y = eff_size(pwdata[8:0]);
          REG_SIZE_Z: reg_size_z = eff_size(pwdata[8:0]);
          default: ;
        endcase
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result sink. It toggles tready in random bursts. On request it stalls
  // for one long stretch so that the block fills up and pushes back.
  initial begin : result_sink
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready_i <= 1'b0;
        rx_holding = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
        rx_holding = 1'b0;
      end else if (no_gaps || $urandom_range(0, 2) != 0) begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat (idle_len() + 1) @(posedge clk_i);
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Valid stays
  // high after the request is taken. The next call lowers it only if it
  // inserts idle cycles, so that valid gets a single assignment per edge.
  task automatic send_req(input logic kind, input logic [2:0] oct);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {5'b0, oct};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stops offering requests and waits until every predicted result has come back.
  task automatic wait_all_results();
    s_axis_tvalid_i <= 1'b0;
    while (voxel_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: a setup phase, then the access phase, which completes when
  // pready is high. The bus stays selected so that writes can follow back to
  // back; the caller releases it after the last one.
  task automatic apb_write(input logic [1:0] reg_idx, input logic [8:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {23'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [8:0] sx, input logic [8:0] sy, input logic [8:0] sz);
    apb_write(REG_SIZE_X, sx);
    apb_write(REG_SIZE_Y, sy);
    apb_write(REG_SIZE_Z, sz);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Next requests with no sweep running give an empty result. A start request
  // with the reset sizes gives a one-voxel sweep, which ends at once.
  task automatic test_idle_requests();
    send_req(KIND_NEXT, 3'd0);
    send_req(KIND_NEXT, 3'd7);
    send_req(KIND_START, 3'd5);
    send_req(KIND_NEXT, 3'd0);
    send_req(KIND_NEXT, 3'd2);
    wait_all_results();
  endtask

  // Complete sweeps of a 2x2x2 grid from opposite corners, plus one request past the end.
  task automatic test_corner_sweeps();
    set_grid(9'd2, 9'd2, 9'd2);
    send_req(KIND_START, 3'd0);
    repeat (8) send_req(KIND_NEXT, 3'd0);
    send_req(KIND_START, 3'd7);
    repeat (9) send_req(KIND_NEXT, 3'd7);
    wait_all_results();
  endtask

  // Sizes of zero act as one, and sizes above the maximum act as the maximum.
  // The full 256 cube is swept from the far corner, which gives the highest index, and from the zero corner.
  task automatic test_extent_clamp();
    set_grid(9'd0, 9'd0, 9'd0);
    send_req(KIND_START, 3'd3);
    send_req(KIND_NEXT, 3'd0);
    wait_all_results();
    set_grid(9'd511, 9'd300, 9'd256);
    send_req(KIND_START, 3'd0);
    repeat (3) send_req(KIND_NEXT, 3'd0);
    send_req(KIND_START, 3'd7);
    repeat (2) send_req(KIND_NEXT, 3'd0);
    wait_all_results();
  endtask

  // A size written in the middle of a sweep takes effect only at the next start.
  task automatic test_resize_mid_sweep();
    set_grid(9'd3, 9'd1, 9'd1);
    send_req(KIND_START, 3'd4);
    send_req(KIND_NEXT, 3'd0);
    wait_all_results();
    set_grid(9'd5, 9'd5, 9'd5);
    repeat (3) send_req(KIND_NEXT, 3'd0);
    send_req(KIND_START, 3'd2);
    repeat (2) send_req(KIND_NEXT, 3'd0);
    wait_all_results();
  endtask

  // The sink stalls for a long time while requests keep coming, so the input
  // side must stop taking requests until the sink resumes.
  task automatic test_backpressure();
    set_grid(9'd4, 9'd4, 9'd4);
    send_req(KIND_START, 3'd6);
    wait_all_results();
    rx_hold_req = 1'b1;
    while (!rx_holding) @(posedge clk_i);
    no_gaps = 1'b1;
    repeat (30) send_req(KIND_NEXT, 3'd0);
    no_gaps = 1'b0;
    wait_all_results();
  endtask

  // Sizes are mostly small so that whole sweeps finish. Some are zero, above
  // the maximum, at it, or 6 to 40; grids over 150 voxels are cut short.
  function automatic logic [8:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return 9'd0;
      1:       return 9'($urandom_range(257, 511));
      2:       return 9'd256;
      3:       return 9'($urandom_range(6, 40));
      default: return 9'($urandom_range(1, 5));
    endcase
  endfunction

  // Random phases. Each one writes new sizes, then runs a few sweeps. Most are
  // a start followed by enough next requests to finish the sweep. Others stop
  // early, or are replaced by random requests.
  task automatic test_random_sweeps();
    int unsigned sent, voxels, n_next;
    logic [8:0]  sx, sy, sz;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_all_results();
      sx = pick_extent();
      sy = pick_extent();
      sz = pick_extent();
      set_grid(sx, sy, sz);
      voxels  = eff_size(sx) * eff_size(sy) * eff_size(sz);
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            send_req(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            sent++;
          end
        end else begin
          send_req(KIND_START, 3'($urandom_range(0, 7)));
          sent++;
          if (voxels <= 150 && $urandom_range(0, 3) != 0) begin
            n_next = voxels + $urandom_range(0, 2);
          end else begin
            n_next = $urandom_range(1, 60);
          end
          repeat (n_next) begin
            send_req(KIND_NEXT, 3'($urandom_range(0, 7)));
            sent++;
          end
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_requests();
    test_corner_sweeps();
    test_extent_clamp();
    test_resize_mid_sweep();
    test_backpressure();
    test_random_sweeps();
    wait_all_results();
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
